// ===== rtl/sna_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sna_pkg: shared types and constants for the slot allocator
// Table geometry, request codes and the structs passed between the blocks.
// ----------------------------------------------------------------------------
package sna_pkg;

    // table geometry: occupancy kept as rows of WORD_W bits
    localparam int SLOT_COUNT = 256;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int WORD_W     = 32;
    localparam int ROWS       = SLOT_COUNT / WORD_W;
    localparam int ROW_W      = $clog2(ROWS);
    localparam int BIT_W      = $clog2(WORD_W);

    // beat field widths
    localparam int ACT_W     = 2;
    localparam int SLOT_IN_W = 8;

    // request codes
    localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;

    // occupancy RAM read and write request
    typedef struct packed {
        logic              rd_en;
        logic [ROW_W-1:0]  rd_addr;
        logic              wr_en;
        logic [ROW_W-1:0]  wr_addr;
        logic [WORD_W-1:0] wr_data;
    } mem_req_t;

    // one result beat
    typedef struct packed {
        logic [SLOT_IN_W-1:0] slot_out;
        logic                 status;
        logic                 occupied;
    } res_t;

endpackage
`default_nettype wire

// ===== rtl/slot_allocator_next_free_hint.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slot_allocator_next_free_hint: free-slot allocator with next-free hint
//
//  channel | dir | tvalid/tready | tdata             | tuser
//  s_      | in  | request beat  | [7:0] slot_in     | [1:0] action
//  m_      | out | result beat   | [7:0] slot_out,   | [0] status
//          |     |               | [8] occupied      |
//
// A request holds the sequencer from its accept in S_IDLE until the output
// register takes its result from S_RESP, where it sits in a register. An add
// also passes through S_NEXT when the following slot lies in the next
// occupancy row, and through S_FIND when the hint has to search for the
// lowest free slot. An unused request code skips the RAM and goes straight to
// S_RESP. The occupancy RAM has a registered read and is read once per step.
// Reset clears the state at once: no clearing pass. A stalled result waits
// in the output register while the next request runs.
// ----------------------------------------------------------------------------
module slot_allocator_next_free_hint
    import sna_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] slot_in
    input  wire logic [1:0]  s_tuser,   // [1:0] action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] slot_out, [8] occupied, rest zero
    output logic [0:0]       m_tuser    // [0] status
);

    mem_req_t          mem_req;
    logic [WORD_W-1:0] mem_rd_data;
    logic              res_valid;
    logic              res_ready;
    res_t              res;

    logic              m_tvalid_reg;
    res_t              m_res_reg;

    sna_occ_mem u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    sna_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_action   (s_tuser),
        .in_slot     (s_tdata),
        .mem_req     (mem_req),
        .mem_rd_data (mem_rd_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    // output register
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, m_res_reg.occupied, m_res_reg.slot_out};
    assign m_tuser  = m_res_reg.status;

    // a result handed over shows on the output next cycle
    a_res_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res_ready |=> m_tvalid)
        else $error("result lost on the way to the output register");

    // a result held back stays put until taken
    a_res_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("pending result changed or dropped");

    // no new request is taken while a result is pending in the sequencer
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && res_valid))
        else $error("request accepted while a result is pending");

    // a refused add never reports a slot
    a_full_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata[7:0] == 8'd0) && !m_tdata[8])
        else $error("full status with nonzero slot or occupied flag");

endmodule
`default_nettype wire

// ===== rtl/sna_occ_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sna_occ_mem: occupancy RAM
// One row of busy bits per address, registered read, write-first forwarding.
// Per-row valid flops make unwritten rows read as all free after reset.
// ----------------------------------------------------------------------------
module sna_occ_mem
    import sna_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire mem_req_t          req,
    output logic [WORD_W-1:0]      rd_data
);

    logic [WORD_W-1:0] mem_q [ROWS];
    logic [ROWS-1:0]   row_vld_reg;
    logic [WORD_W-1:0] rd_data_reg;
    logic              rd_vld_reg;

    // storage array, no reset
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem_q[req.wr_addr] <= req.wr_data;
        end
    end

    // row valid bits, cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg <= '0;
        end else if (req.wr_en) begin
            row_vld_reg[req.wr_addr] <= 1'b1;
        end
    end

    // registered read, forwards a same-cycle write to the same row
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
        end else if (req.rd_en) begin
            if (req.wr_en && (req.wr_addr == req.rd_addr)) begin
                rd_vld_reg <= 1'b1;
            end else begin
                rd_vld_reg <= row_vld_reg[req.rd_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            if (req.wr_en && (req.wr_addr == req.rd_addr)) begin
                rd_data_reg <= req.wr_data;
            end else begin
                rd_data_reg <= mem_q[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule
`default_nettype wire

// ===== rtl/sna_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sna_ctrl: request sequencer
// Read-modify-write of occupancy rows, hint update and free-slot search.
// Keeps one "row full" flag per row to pick the row for the search.
// ----------------------------------------------------------------------------
module sna_ctrl
    import sna_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [ACT_W-1:0]     in_action,
    input  wire logic [SLOT_IN_W-1:0] in_slot,
    output mem_req_t                  mem_req,
    input  wire logic [WORD_W-1:0]    mem_rd_data,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output res_t                      res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_NEXT,
        S_FIND,
        S_RESP
    } state_t;

    state_t               state_reg, state_next;
    logic [ACT_W-1:0]     act_reg, act_next;
    logic [SLOT_IN_W-1:0] slot_reg, slot_next;
    logic [SLOT_W-1:0]    hint_reg, hint_next;
    logic [ROWS-1:0]      full_reg, full_next;
    logic [ROW_W-1:0]     srch_row_reg, srch_row_next;
    res_t                 res_reg, res_next;

    logic [SLOT_W-1:0]    tgt;
    logic [ROW_W-1:0]     tgt_row;
    logic [BIT_W-1:0]     tgt_bit;
    logic [WORD_W-1:0]    tgt_mask;
    logic [WORD_W-1:0]    set_word;
    logic [ROWS-1:0]      full_upd;
    logic [ROWS-1:0]      srch_src;
    logic [ROW_W:0]       srch_hit;
    logic                 in_range;
    logic                 not_top;
    logic                 bit_last;
    logic [SLOT_W-1:0]    in_idx;

    // lowest clear bit of a row
    function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_W-1:0] w);
        logic [BIT_W-1:0] p;
        p = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!w[i]) p = BIT_W'(i);
        end
        return p;
    endfunction

    // lowest row that is not full, with a found flag on top
    function automatic logic [ROW_W:0] first_open(input logic [ROWS-1:0] f);
        logic [ROW_W:0] r;
        r = '0;
        for (int i = ROWS - 1; i >= 0; i--) begin
            if (!f[i]) r = {1'b1, ROW_W'(i)};
        end
        return r;
    endfunction

    // slot addressed by the current request
    assign in_idx   = SLOT_W'(in_slot);
    assign tgt      = (act_reg == ACT_ADD) ? hint_reg : SLOT_W'(slot_reg);
    assign tgt_row  = tgt[SLOT_W-1:BIT_W];
    assign tgt_bit  = tgt[BIT_W-1:0];
    assign tgt_mask = WORD_W'(1) << tgt_bit;
    assign set_word = mem_rd_data | tgt_mask;
    assign in_range = (32'(slot_reg) < SLOT_COUNT);
    assign not_top  = (32'(hint_reg) != SLOT_COUNT - 1);
    assign bit_last = (tgt_bit == BIT_W'(WORD_W - 1));

    // full flags after granting the hint slot
    always_comb begin
        full_upd          = full_reg;
        full_upd[tgt_row] = &set_word;
    end

    assign srch_src = (state_reg == S_LOOK) ? full_upd : full_reg;
    assign srch_hit = first_open(srch_src);

    // next-state and datapath
    always_comb begin
        state_next    = state_reg;
        act_next      = act_reg;
        slot_next     = slot_reg;
        hint_next     = hint_reg;
        full_next     = full_reg;
        srch_row_next = srch_row_reg;
        res_next      = res_reg;
        mem_req       = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    act_next          = in_action;
                    slot_next         = in_slot;
                    res_next.slot_out = in_slot;
                    res_next.status   = 1'b0;
                    res_next.occupied = 1'b0;
                    case (in_action) inside
                        ACT_ADD: begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = hint_reg[SLOT_W-1:BIT_W];
                            state_next      = S_LOOK;
                        end
                        ACT_REMOVE, ACT_QUERY: begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = in_idx[SLOT_W-1:BIT_W];
                            state_next      = S_LOOK;
                        end
                        default: begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            S_LOOK: begin
                state_next = S_RESP;
                case (act_reg)
                    ACT_ADD: begin
                        if (mem_rd_data[tgt_bit]) begin
                            // table full: refuse, no change
                            res_next.slot_out = '0;
                            res_next.status   = 1'b1;
                        end else begin
                            mem_req.wr_en     = 1'b1;
                            mem_req.wr_addr   = tgt_row;
                            mem_req.wr_data   = set_word;
                            full_next         = full_upd;
                            res_next.slot_out = SLOT_IN_W'(hint_reg);
                            if (not_top && !bit_last &&
                                !set_word[BIT_W'(tgt_bit + BIT_W'(1))]) begin
                                hint_next = hint_reg + SLOT_W'(1);
                            end else if (not_top && bit_last) begin
                                // following slot sits in the next row
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = tgt_row + ROW_W'(1);
                                state_next      = S_NEXT;
                            end else if (srch_hit[ROW_W]) begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = srch_hit[ROW_W-1:0];
                                srch_row_next   = srch_hit[ROW_W-1:0];
                                state_next      = S_FIND;
                            end
                        end
                    end
                    ACT_REMOVE: begin
                        if (in_range) begin
                            mem_req.wr_en      = 1'b1;
                            mem_req.wr_addr    = tgt_row;
                            mem_req.wr_data    = mem_rd_data & ~tgt_mask;
                            full_next[tgt_row] = 1'b0;
                            hint_next          = tgt;
                        end
                    end
                    ACT_QUERY: begin
                        res_next.occupied = in_range & mem_rd_data[tgt_bit];
                    end
                    default: begin
                    end
                endcase
            end

            S_NEXT: begin
                state_next = S_RESP;
                if (!mem_rd_data[0]) begin
                    hint_next = hint_reg + SLOT_W'(1);
                end else if (srch_hit[ROW_W]) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = srch_hit[ROW_W-1:0];
                    srch_row_next   = srch_hit[ROW_W-1:0];
                    state_next      = S_FIND;
                end
            end

            S_FIND: begin
                hint_next  = {srch_row_reg, first_zero(mem_rd_data)};
                state_next = S_RESP;
            end

            S_RESP: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            hint_reg  <= '0;
            full_reg  <= '0;
        end else begin
            state_reg <= state_next;
            hint_reg  <= hint_next;
            full_reg  <= full_next;
        end
        act_reg      <= act_next;
        slot_reg     <= slot_next;
        srch_row_reg <= srch_row_next;
        res_reg      <= res_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESP);
    assign res       = res_reg;

endmodule
`default_nettype wire
